// ----- design/i2c_master_bit_engine_core_defines.svh -----
// assertion macros used by the bit engine sequencer
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define I2CBE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define I2CBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/i2cbe_pkg.sv -----
// types, codes and constants of the i2c master bit engine
`default_nettype none

package i2cbe_pkg;

  localparam int DELAY_COUNTER_WIDTH = 16;
  localparam int HALF_PERIOD_WIDTH   = 16;
  localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_RESET = 16'd4;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_RACK  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;

  typedef enum logic [4:0] {
    PH_IDLE         = 5'd0,
    PH_STA_SCL_HI   = 5'd1,
    PH_STA_SDA_HI   = 5'd2,
    PH_STA_SDA_LO   = 5'd3,
    PH_STA_SCL_LO   = 5'd4,
    PH_STO_SCL_LO   = 5'd5,
    PH_STO_SDA_LO   = 5'd6,
    PH_STO_SCL_HI   = 5'd7,
    PH_STO_SDA_HI   = 5'd8,
    PH_RACK_SDA_HI  = 5'd9,
    PH_RACK_SCL_HI  = 5'd10,
    PH_RACK_SAMPLE  = 5'd11,
    PH_RACK_SDA_LO  = 5'd12,
    PH_SACK_SCL_LO  = 5'd13,
    PH_SACK_SDA_LO  = 5'd14,
    PH_SACK_SCL_HI  = 5'd15,
    PH_SACK_SCL_END = 5'd16,
    PH_WR_SCL_LO    = 5'd17,
    PH_WR_SDA_BIT   = 5'd18,
    PH_WR_SCL_HI    = 5'd19,
    PH_WR_SCL_END   = 5'd20,
    PH_RD_SDA_HI    = 5'd21,
    PH_RD_SCL_HI    = 5'd22,
    PH_RD_SAMPLE    = 5'd23
  } phase_t;

  typedef struct packed {
    logic       sda_in;
    logic [7:0] tx_byte;
    logic [2:0] op;
    logic       cmd_valid;
  } cmd_t;

  // packed so that scl sits in bit 0 of tdata
  typedef struct packed {
    logic [2:0] pad;
    logic       ack_bit;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda;
    logic       scl;
  } result_t;

  function automatic phase_t first_phase(input logic [2:0] op);
    phase_t ph;
    case (op)
      OP_START: ph = PH_STA_SCL_HI;
      OP_STOP:  ph = PH_STO_SCL_LO;
      OP_WRITE: ph = PH_WR_SCL_LO;
      OP_READ:  ph = PH_RD_SDA_HI;
      OP_RACK:  ph = PH_RACK_SDA_HI;
      OP_SACK:  ph = PH_SACK_SCL_LO;
      default:  ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

// ----- design/i2cbe_seq.sv -----
// pin sequencer: bus state registers and the one-tick step logic
`default_nettype none
`include "i2c_master_bit_engine_core_defines.svh"

module i2cbe_seq (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        step_en,
  input  wire i2cbe_pkg::cmd_t                             cmd,
  input  wire logic [i2cbe_pkg::HALF_PERIOD_WIDTH-1:0]     half_period,
  output i2cbe_pkg::result_t                               result
);

  localparam int DW = i2cbe_pkg::DELAY_COUNTER_WIDTH;

  i2cbe_pkg::phase_t phase, phase_next;
  logic [2:0]    bit_index, bit_index_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic [DW-1:0] delay_count, delay_count_next;
  logic          scl_level, scl_level_next;
  logic          sda_level, sda_level_next;
  logic          ack_store, ack_store_next;
  logic [7:0]    rx_hold, rx_hold_next;
  logic          busy, done;
  logic          fin, need_delay;
  logic [DW-1:0] delay_load;

  always_comb begin
    delay_load = DW'(half_period);
    if (delay_load == '0) begin
      delay_load = DW'(1);
    end
  end

  always_comb begin
    phase_next       = phase;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    delay_count_next = delay_count;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    ack_store_next   = ack_store;
    rx_hold_next     = rx_hold;
    busy             = 1'b0;
    done             = 1'b0;
    fin              = 1'b0;
    need_delay       = 1'b0;

    // a command is taken only when idle; unknown op codes leave it idle
    if (phase == i2cbe_pkg::PH_IDLE && cmd.cmd_valid) begin
      phase_next       = i2cbe_pkg::first_phase(cmd.op);
      bit_index_next   = 3'd0;
      shift_byte_next  = (cmd.op == i2cbe_pkg::OP_WRITE) ? cmd.tx_byte : 8'd0;
      delay_count_next = '0;
    end

    if (phase_next != i2cbe_pkg::PH_IDLE) begin
      busy = 1'b1;
      if (delay_count_next != '0) begin
        delay_count_next = delay_count_next - DW'(1);
        fin = (delay_count_next == '0);
      end else begin
        case (phase_next)
          i2cbe_pkg::PH_STA_SCL_HI:   scl_level_next = 1'b1;
          i2cbe_pkg::PH_STA_SDA_HI: begin
            sda_level_next = 1'b1;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_STA_SDA_LO: begin
            sda_level_next = 1'b0;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_STA_SCL_LO:   scl_level_next = 1'b0;
          i2cbe_pkg::PH_STO_SCL_LO:   scl_level_next = 1'b0;
          i2cbe_pkg::PH_STO_SDA_LO:   sda_level_next = 1'b0;
          i2cbe_pkg::PH_STO_SCL_HI: begin
            scl_level_next = 1'b1;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_STO_SDA_HI:   sda_level_next = 1'b1;
          i2cbe_pkg::PH_RACK_SDA_HI:  sda_level_next = 1'b1;
          i2cbe_pkg::PH_RACK_SCL_HI: begin
            scl_level_next = 1'b1;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_RACK_SAMPLE: begin
            ack_store_next = cmd.sda_in;
            scl_level_next = 1'b0;
          end
          i2cbe_pkg::PH_RACK_SDA_LO:  sda_level_next = 1'b0;
          i2cbe_pkg::PH_SACK_SCL_LO: begin
            scl_level_next = 1'b0;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_SACK_SDA_LO: begin
            sda_level_next = 1'b0;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_SACK_SCL_HI: begin
            scl_level_next = 1'b1;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_SACK_SCL_END: scl_level_next = 1'b0;
          i2cbe_pkg::PH_WR_SCL_LO:    scl_level_next = 1'b0;
          i2cbe_pkg::PH_WR_SDA_BIT:   sda_level_next = shift_byte_next[3'd7 - bit_index_next];
          i2cbe_pkg::PH_WR_SCL_HI: begin
            scl_level_next = 1'b1;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_WR_SCL_END:   scl_level_next = 1'b0;
          i2cbe_pkg::PH_RD_SDA_HI:    sda_level_next = 1'b1;
          i2cbe_pkg::PH_RD_SCL_HI: begin
            scl_level_next = 1'b1;
            need_delay = 1'b1;
          end
          i2cbe_pkg::PH_RD_SAMPLE: begin
            shift_byte_next = {shift_byte_next[6:0], cmd.sda_in};
            scl_level_next = 1'b0;
            need_delay = 1'b1;
          end
          default:                    phase_next = i2cbe_pkg::PH_IDLE;
        endcase
        if (need_delay) begin
          delay_count_next = delay_load;
        end else begin
          fin = (phase_next != i2cbe_pkg::PH_IDLE);
        end
      end
    end

    // step finished: advance the phase or end the command
    if (fin) begin
      case (phase_next)
        i2cbe_pkg::PH_STA_SCL_LO, i2cbe_pkg::PH_STO_SDA_HI, i2cbe_pkg::PH_RACK_SDA_LO,
        i2cbe_pkg::PH_SACK_SCL_END, i2cbe_pkg::PH_WR_SCL_END: begin
          phase_next = i2cbe_pkg::PH_IDLE;
          done = 1'b1;
        end
        i2cbe_pkg::PH_WR_SCL_HI: begin
          if (bit_index_next == 3'd7) begin
            phase_next = i2cbe_pkg::PH_WR_SCL_END;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next = i2cbe_pkg::PH_WR_SCL_LO;
          end
        end
        i2cbe_pkg::PH_RD_SAMPLE: begin
          if (bit_index_next == 3'd7) begin
            rx_hold_next = shift_byte_next;
            phase_next = i2cbe_pkg::PH_IDLE;
            done = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next = i2cbe_pkg::PH_RD_SCL_HI;
          end
        end
        default: begin
          phase_next = i2cbe_pkg::phase_t'(phase_next + 5'd1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= i2cbe_pkg::PH_IDLE;
      bit_index   <= 3'd0;
      shift_byte  <= 8'd0;
      delay_count <= '0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      ack_store   <= 1'b0;
      rx_hold     <= 8'd0;
    end else if (step_en) begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      delay_count <= delay_count_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      ack_store   <= ack_store_next;
      rx_hold     <= rx_hold_next;
    end
  end

  always_comb begin
    result          = '0;
    result.scl      = scl_level_next;
    result.sda      = sda_level_next;
    result.busy_res = busy;
    result.done_res = done;
    result.rx_byte  = rx_hold_next;
    result.ack_bit  = ack_store_next;
  end

  `I2CBE_ASSERT_NEXT(a_done_goes_idle, clk, rst, step_en && done, phase == i2cbe_pkg::PH_IDLE, "command finished but phase not idle")
  `I2CBE_ASSERT_SAME(a_delay_only_busy, clk, rst, delay_count != '0, phase != i2cbe_pkg::PH_IDLE, "delay pending while idle")
  `I2CBE_ASSERT_NEXT(a_hold_no_step, clk, rst, !step_en, $stable(phase) && $stable(delay_count), "state moved without a step")
  `I2CBE_ASSERT_NEXT(a_idle_pins_hold, clk, rst, step_en && phase == i2cbe_pkg::PH_IDLE && !cmd.cmd_valid, $stable(scl_level) && $stable(sda_level), "pins moved in an idle tick")

endmodule

`default_nettype wire

// ----- design/i2cbe_out_reg.sv -----
// result register between the sequencer and the output stream
`default_nettype none

module i2cbe_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire i2cbe_pkg::result_t  result,
  output logic                     can_load,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [15:0]              m_axis_tdata
);

  i2cbe_pkg::result_t hold;

  assign can_load      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = 16'(hold);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can_load) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      hold <= result;
    end
  end

endmodule

`default_nettype wire

// ----- design/i2c_master_bit_engine_core.sv -----
// i2c master bit engine: one tick per input transaction, one result per tick
// path: a tick accepted on s_axis is registered in the input register, its result then in the output register on m_axis
// throughput: one tick per clock cycle while m_axis is ready; the sequencer steps once per tick
// pin timing: each bus change is one tick, each delay step holds half_period_ticks ticks (one tick if zero)
// reset (rst, synchronous): both lines released, engine idle, half_period_ticks back to 4
`default_nettype none

module i2c_master_bit_engine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // cmd_valid, op[2:0], tx_byte[7:0], sda_in, zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // scl, sda, busy_res, done_res, rx_byte[7:0], ack_bit, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data       // half_period_ticks
);

  logic [i2cbe_pkg::HALF_PERIOD_WIDTH-1:0] half_period;
  logic                                    in_valid;
  i2cbe_pkg::cmd_t                         in_cmd;
  i2cbe_pkg::result_t                      result;
  logic                                    out_can_load;
  logic                                    step_en;

  assign cfg_ready     = 1'b1;
  assign step_en       = in_valid && out_can_load;
  assign s_axis_tready = !in_valid || out_can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cbe_pkg::HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd.cmd_valid <= s_axis_tdata[0];
      in_cmd.op        <= s_axis_tdata[3:1];
      in_cmd.tx_byte   <= s_axis_tdata[11:4];
      in_cmd.sda_in    <= s_axis_tdata[12];
    end
  end

  i2cbe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step_en     (step_en),
    .cmd         (in_cmd),
    .half_period (half_period),
    .result      (result)
  );

  i2cbe_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step_en),
    .result        (result),
    .can_load      (out_can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_i2c_master_bit_engine_core.sv -----
// self-checking testbench for the i2c master bit engine core
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine_core;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int SDA_LOW        = 0;
  localparam int SDA_HIGH       = 1;
  localparam int SDA_RANDOM     = 2;
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  i2c_master_bit_engine_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // cmd_valid, op[2:0], tx_byte[7:0], sda_in, zero pad
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // scl, sda, busy_res, done_res, rx_byte[7:0], ack_bit, pad
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)        // half_period_ticks
  );

  always #2 clk = ~clk;

  // predicted engine state
  i2cbe_pkg::phase_t bus_phase   = i2cbe_pkg::PH_IDLE;
  logic [2:0]        bit_pos     = '0;
  logic [7:0]        shift_reg   = '0;
  logic [15:0]       hold_left   = '0;
  logic              scl_q       = 1'b1;
  logic              sda_q       = 1'b1;
  logic              ack_q       = 1'b0;
  logic [7:0]        rx_q        = '0;
  logic [15:0]       half_period = i2cbe_pkg::HALF_PERIOD_RESET;

  i2cbe_pkg::result_t expected_pins_q[$];
  logic [2:0]         op_plan[$];
  i2cbe_pkg::result_t want_r;
  i2cbe_pkg::result_t got_r;
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  int                 stall_roll;
  bit                 gaps_on = 1'b1;
  bit                 stalls_on = 1'b1;

  function automatic i2cbe_pkg::phase_t cmd_entry(input logic [2:0] op);
    case (op)
      i2cbe_pkg::OP_START: return i2cbe_pkg::PH_STA_SCL_HI;
      i2cbe_pkg::OP_STOP:  return i2cbe_pkg::PH_STO_SCL_LO;
      i2cbe_pkg::OP_WRITE: return i2cbe_pkg::PH_WR_SCL_LO;
      i2cbe_pkg::OP_READ:  return i2cbe_pkg::PH_RD_SDA_HI;
      i2cbe_pkg::OP_RACK:  return i2cbe_pkg::PH_RACK_SDA_HI;
      default:             return i2cbe_pkg::PH_SACK_SCL_LO;
    endcase
  endfunction

  // move to the next step; returns 1 when the command is complete
  function automatic logic step_finished();
    case (bus_phase)
      i2cbe_pkg::PH_STA_SCL_LO, i2cbe_pkg::PH_STO_SDA_HI, i2cbe_pkg::PH_RACK_SDA_LO,
      i2cbe_pkg::PH_SACK_SCL_END, i2cbe_pkg::PH_WR_SCL_END: begin
        bus_phase = i2cbe_pkg::PH_IDLE;
        return 1'b1;
      end
      i2cbe_pkg::PH_WR_SCL_HI: begin
        if (bit_pos == 3'd7) begin
          bus_phase = i2cbe_pkg::PH_WR_SCL_END;
        end else begin
          bit_pos   = bit_pos + 3'd1;
          bus_phase = i2cbe_pkg::PH_WR_SCL_LO;
        end
        return 1'b0;
      end
      i2cbe_pkg::PH_RD_SAMPLE: begin
        if (bit_pos == 3'd7) begin
          rx_q      = shift_reg;
          bus_phase = i2cbe_pkg::PH_IDLE;
          return 1'b1;
        end
        bit_pos   = bit_pos + 3'd1;
        bus_phase = i2cbe_pkg::PH_RD_SCL_HI;
        return 1'b0;
      end
      default: begin
        bus_phase = i2cbe_pkg::phase_t'(bus_phase + 5'd1);
        return 1'b0;
      end
    endcase
  endfunction

  // pin change of the current step; returns 1 when a hold follows
  function automatic logic bus_change(input logic sda_in);
    case (bus_phase)
      i2cbe_pkg::PH_STA_SCL_HI:   begin scl_q = 1'b1; return 1'b0; end
      i2cbe_pkg::PH_STA_SDA_HI:   begin sda_q = 1'b1; return 1'b1; end
      i2cbe_pkg::PH_STA_SDA_LO:   begin sda_q = 1'b0; return 1'b1; end
      i2cbe_pkg::PH_STA_SCL_LO:   begin scl_q = 1'b0; return 1'b0; end
      i2cbe_pkg::PH_STO_SCL_LO:   begin scl_q = 1'b0; return 1'b0; end
      i2cbe_pkg::PH_STO_SDA_LO:   begin sda_q = 1'b0; return 1'b0; end
      i2cbe_pkg::PH_STO_SCL_HI:   begin scl_q = 1'b1; return 1'b1; end
      i2cbe_pkg::PH_STO_SDA_HI:   begin sda_q = 1'b1; return 1'b0; end
      i2cbe_pkg::PH_RACK_SDA_HI:  begin sda_q = 1'b1; return 1'b0; end
      i2cbe_pkg::PH_RACK_SCL_HI:  begin scl_q = 1'b1; return 1'b1; end
      i2cbe_pkg::PH_RACK_SAMPLE:  begin ack_q = sda_in; scl_q = 1'b0; return 1'b0; end
      i2cbe_pkg::PH_RACK_SDA_LO:  begin sda_q = 1'b0; return 1'b0; end
      i2cbe_pkg::PH_SACK_SCL_LO:  begin scl_q = 1'b0; return 1'b1; end
      i2cbe_pkg::PH_SACK_SDA_LO:  begin sda_q = 1'b0; return 1'b1; end
      i2cbe_pkg::PH_SACK_SCL_HI:  begin scl_q = 1'b1; return 1'b1; end
      i2cbe_pkg::PH_SACK_SCL_END: begin scl_q = 1'b0; return 1'b0; end
      i2cbe_pkg::PH_WR_SCL_LO:    begin scl_q = 1'b0; return 1'b0; end
      i2cbe_pkg::PH_WR_SDA_BIT:   begin sda_q = shift_reg[3'd7 - bit_pos]; return 1'b0; end
      i2cbe_pkg::PH_WR_SCL_HI:    begin scl_q = 1'b1; return 1'b1; end
      i2cbe_pkg::PH_WR_SCL_END:   begin scl_q = 1'b0; return 1'b0; end
      i2cbe_pkg::PH_RD_SDA_HI:    begin sda_q = 1'b1; return 1'b0; end
      i2cbe_pkg::PH_RD_SCL_HI:    begin scl_q = 1'b1; return 1'b1; end
      i2cbe_pkg::PH_RD_SAMPLE: begin
        shift_reg = {shift_reg[6:0], sda_in};
        scl_q     = 1'b0;
        return 1'b1;
      end
      default: begin
        bus_phase = i2cbe_pkg::PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // advance the engine by one tick and return the pin levels and status it shows
  function automatic i2cbe_pkg::result_t predict_pins(input i2cbe_pkg::cmd_t c);
    i2cbe_pkg::result_t r;
    logic               busy;
    logic               done;
    busy = 1'b0;
    done = 1'b0;
    if (bus_phase == i2cbe_pkg::PH_IDLE && c.cmd_valid && c.op <= i2cbe_pkg::OP_SACK) begin
      bus_phase = cmd_entry(c.op);
      bit_pos   = '0;
      shift_reg = (c.op == i2cbe_pkg::OP_WRITE) ? c.tx_byte : 8'd0;
      hold_left = '0;
    end
    if (bus_phase != i2cbe_pkg::PH_IDLE) begin
      busy = 1'b1;
      if (hold_left != 0) begin
        hold_left = hold_left - 16'd1;
        if (hold_left == 0) done = step_finished();
      end else if (bus_change(c.sda_in)) begin
        // a zero half period still holds for one tick
        hold_left = (half_period == 0) ? 16'd1 : half_period;
      end else if (bus_phase != i2cbe_pkg::PH_IDLE) begin
        done = step_finished();
      end
    end
    r          = '0;
    r.scl      = scl_q;
    r.sda      = sda_q;
    r.busy_res = busy;
    r.done_res = done;
    r.rx_byte  = rx_q;
    r.ack_bit  = ack_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // compare every result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_r = i2cbe_pkg::result_t'(m_axis_tdata);
      if (expected_pins_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want_r = expected_pins_q.pop_front();
        check_field("scl", 8'(want_r.scl), 8'(got_r.scl));
        check_field("sda", 8'(want_r.sda), 8'(got_r.sda));
        check_field("busy_res", 8'(want_r.busy_res), 8'(got_r.busy_res));
        check_field("done_res", 8'(want_r.done_res), 8'(got_r.done_res));
        check_field("rx_byte", want_r.rx_byte, got_r.rx_byte);
        check_field("ack_bit", 8'(want_r.ack_bit), 8'(got_r.ack_bit));
      end
    end
  end

  // receiver back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (rst || !stalls_on) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 12) begin
        m_axis_tready <= 1'b0;
        stall_left    <= (stall_roll < 2) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one tick transaction; valid stays high so back-to-back ticks need no gap
  task automatic send_tick(input i2cbe_pkg::cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'd0, c};
    do @(posedge clk); while (!s_axis_tready);
    expected_pins_q.push_back(predict_pins(c));
  endtask

  task automatic run_tick(input logic valid, input logic [2:0] op, input logic [7:0] tx,
                          input int sda_sel);
    i2cbe_pkg::cmd_t c;
    c.cmd_valid = valid;
    c.op        = op;
    c.tx_byte   = tx;
    c.sda_in    = (sda_sel == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : (sda_sel == SDA_HIGH);
    send_tick(c);
  endtask

  task automatic idle_tick(input int sda_sel);
    run_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), sda_sel);
  endtask

  task automatic drain_bus(input int sda_sel);
    while (bus_phase != i2cbe_pkg::PH_IDLE) idle_tick(sda_sel);
  endtask

  task automatic issue(input logic [2:0] op, input logic [7:0] tx, input int sda_sel);
    run_tick(1'b1, op, tx, sda_sel);
    drain_bus(sda_sel);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (expected_pins_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [15:0] value);
    drain_bus(SDA_RANDOM);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    half_period = value;
  endtask

  task automatic test_default_period();
    issue(i2cbe_pkg::OP_START, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_WRITE, 8'hA5, SDA_RANDOM);
    issue(i2cbe_pkg::OP_RACK, 8'h00, SDA_LOW);
    issue(i2cbe_pkg::OP_READ, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_SACK, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_RACK, 8'h00, SDA_HIGH);
    issue(i2cbe_pkg::OP_STOP, 8'h00, SDA_RANDOM);
  endtask

  // commands while busy and undefined ops must leave the engine alone
  task automatic test_ignored_commands();
    run_tick(1'b1, i2cbe_pkg::OP_START, 8'h00, SDA_RANDOM);
    run_tick(1'b1, i2cbe_pkg::OP_WRITE, 8'hFF, SDA_RANDOM);
    run_tick(1'b1, i2cbe_pkg::OP_STOP, 8'h00, SDA_RANDOM);
    drain_bus(SDA_RANDOM);
    run_tick(1'b1, OP_BAD_LO, 8'h3C, SDA_HIGH);
    run_tick(1'b1, OP_BAD_HI, 8'hC3, SDA_LOW);
    idle_tick(SDA_RANDOM);
  endtask

  task automatic test_byte_extremes();
    issue(i2cbe_pkg::OP_WRITE, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_WRITE, 8'hFF, SDA_RANDOM);
    issue(i2cbe_pkg::OP_READ, 8'h00, SDA_HIGH);
    issue(i2cbe_pkg::OP_READ, 8'h00, SDA_LOW);
  endtask

  task automatic test_zero_period();
    write_half_period(16'd0);
    issue(i2cbe_pkg::OP_START, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM);
    issue(i2cbe_pkg::OP_RACK, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_READ, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_STOP, 8'h00, SDA_RANDOM);
  endtask

  task automatic test_min_period();
    write_half_period(16'd1);
    issue(i2cbe_pkg::OP_SACK, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_RACK, 8'h00, SDA_RANDOM);
    issue(i2cbe_pkg::OP_WRITE, 8'h5A, SDA_RANDOM);
  endtask

  // long hold: a stop has a single hold step, so it keeps the run short
  task automatic test_long_period();
    gaps_on = 1'b0;
    write_half_period(16'd32);
    issue(i2cbe_pkg::OP_STOP, 8'h00, SDA_RANDOM);
    gaps_on = 1'b1;
  endtask

  // start, address, ack, one to three data bytes each with its ack, stop
  task automatic plan_frame();
    int n_bytes;
    n_bytes = $urandom_range(1, 3);
    op_plan.push_back(i2cbe_pkg::OP_START);
    op_plan.push_back(i2cbe_pkg::OP_WRITE);
    op_plan.push_back(i2cbe_pkg::OP_RACK);
    repeat (n_bytes) begin
      if ($urandom_range(0, 1) != 0) begin
        op_plan.push_back(i2cbe_pkg::OP_WRITE);
        op_plan.push_back(i2cbe_pkg::OP_RACK);
      end else begin
        op_plan.push_back(i2cbe_pkg::OP_READ);
        op_plan.push_back(i2cbe_pkg::OP_SACK);
      end
    end
    op_plan.push_back(i2cbe_pkg::OP_STOP);
  endtask

  task automatic random_segment(input logic [15:0] hp, input bit gaps, input bit stalls,
                                input int n_ticks);
    int roll;
    write_half_period(hp);
    gaps_on   = gaps;
    stalls_on = stalls;
    repeat (n_ticks) begin
      roll = $urandom_range(0, 99);
      if (bus_phase == i2cbe_pkg::PH_IDLE) begin
        if (roll < 80) begin
          if (op_plan.size() == 0) plan_frame();
          run_tick(1'b1, op_plan.pop_front(), 8'($urandom_range(0, 255)), SDA_RANDOM);
        end else if (roll < 88) begin
          run_tick(1'b1, 3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)), SDA_RANDOM);
        end else begin
          idle_tick(SDA_RANDOM);
        end
      end else if (roll < 10) begin
        run_tick(1'b1, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), SDA_RANDOM);
      end else begin
        idle_tick(SDA_RANDOM);
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    random_segment(16'd1, 1'b1, 1'b1, 24);
    random_segment(16'd2, 1'b0, 1'b0, 24);
    random_segment(16'd3, 1'b1, 1'b1, 24);
    random_segment(16'd5, 1'b1, 1'b0, 24);
    random_segment(16'($urandom_range(1, 12)), 1'b1, 1'b1, 24);
    random_segment(16'd0, 1'b0, 1'b1, 24);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_period();
    test_ignored_commands();
    test_zero_period();
    test_min_period();
    test_byte_extremes();
    test_long_period();
    test_random_traffic();
    wait_results();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
